// ----- rtl/core/numeric_literal_parser_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the integer literal parser
// Shared concurrent assertion forms; clocked on clk, quiet during reset.
// ---------------------------------------------------------------------------
`ifndef NUMERIC_LITERAL_PARSER_MACROS_SVH
`define NUMERIC_LITERAL_PARSER_MACROS_SVH

// Same-cycle implication
`define NLP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("numeric_literal_parser: assertion failed");

// Next-cycle implication
`define NLP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("numeric_literal_parser: assertion failed");

`endif

// ----- rtl/core/nlp_pkg.sv -----
// ---------------------------------------------------------------------------
// nlp_pkg
// Types and character codes shared by the integer literal parser.
// ---------------------------------------------------------------------------
package nlp_pkg;

  localparam int CHAR_W  = 8;
  localparam int VALUE_W = 32;

  // Number base selected by the prefix
  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_BIN = 2'd1,
    RADIX_OCT = 2'd2,
    RADIX_HEX = 2'd3
  } radix_t;

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_ONE   = 8'h31;  // '1'
  localparam logic [CHAR_W-1:0] CHAR_SEVEN = 8'h37;  // '7'
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;  // '9'
  localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;  // 'A'
  localparam logic [CHAR_W-1:0] CHAR_UP_F  = 8'h46;  // 'F'
  localparam logic [CHAR_W-1:0] CHAR_LO_A  = 8'h61;  // 'a'
  localparam logic [CHAR_W-1:0] CHAR_LO_Z  = 8'h7a;  // 'z'
  localparam logic [CHAR_W-1:0] CHAR_B     = 8'h62;  // 'b'
  localparam logic [CHAR_W-1:0] CHAR_X     = 8'h78;  // 'x'
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;  // '-'
  localparam logic [CHAR_W-1:0] CASE_FOLD  = 8'hdf;  // clears the lowercase bit

endpackage

// ----- rtl/core/nlp_digit_step.sv -----
// ---------------------------------------------------------------------------
// nlp_digit_step
// Decodes one character as a digit of the given base and folds it into the
// accumulator (acc * base + digit, mod 2^32); a non-digit flags malformed.
// ---------------------------------------------------------------------------
module nlp_digit_step (
  input  logic [nlp_pkg::CHAR_W-1:0]  char_i,
  input  nlp_pkg::radix_t             radix_i,
  input  logic [nlp_pkg::VALUE_W-1:0] accum_i,
  input  logic                        malformed_i,
  output logic [nlp_pkg::VALUE_W-1:0] accum_o,
  output logic                        malformed_o
);

  logic                        dig_ok;
  logic [3:0]                  dig_val;
  logic [nlp_pkg::CHAR_W-1:0]  folded;
  logic [nlp_pkg::CHAR_W-1:0]  dig_off;
  logic [nlp_pkg::VALUE_W-1:0] scaled;

  // Digit decode per base
  always_comb begin
    dig_ok  = 1'b0;
    dig_off = char_i - nlp_pkg::CHAR_ZERO;
    folded  = (char_i inside {[nlp_pkg::CHAR_LO_A:nlp_pkg::CHAR_LO_Z]}) ?
              (char_i & nlp_pkg::CASE_FOLD) : char_i;
    case (radix_i)
      nlp_pkg::RADIX_BIN: dig_ok = char_i inside {[nlp_pkg::CHAR_ZERO:nlp_pkg::CHAR_ONE]};
      nlp_pkg::RADIX_OCT: dig_ok = char_i inside {[nlp_pkg::CHAR_ZERO:nlp_pkg::CHAR_SEVEN]};
      nlp_pkg::RADIX_HEX: begin
        if (char_i inside {[nlp_pkg::CHAR_ZERO:nlp_pkg::CHAR_NINE]}) begin
          dig_ok = 1'b1;
        end else if (folded inside {[nlp_pkg::CHAR_UP_A:nlp_pkg::CHAR_UP_F]}) begin
          dig_ok  = 1'b1;
          dig_off = folded - nlp_pkg::CHAR_UP_A + 8'd10;
        end
      end
      default: dig_ok = char_i inside {[nlp_pkg::CHAR_ZERO:nlp_pkg::CHAR_NINE]};
    endcase
    dig_val = dig_off[3:0];
  end

  // acc * base as shifts; base ten is 8a + 2a
  always_comb begin
    case (radix_i)
      nlp_pkg::RADIX_BIN: scaled = {accum_i[30:0], 1'b0};
      nlp_pkg::RADIX_OCT: scaled = {accum_i[28:0], 3'b000};
      nlp_pkg::RADIX_HEX: scaled = {accum_i[27:0], 4'b0000};
      default:            scaled = {accum_i[28:0], 3'b000} + {accum_i[30:0], 1'b0};
    endcase
  end

  // Once malformed, the accumulator is frozen
  always_comb begin
    malformed_o = malformed_i | ~dig_ok;
    if (!dig_ok || malformed_i) begin
      accum_o = accum_i;
    end else begin
      accum_o = scaled + {{(nlp_pkg::VALUE_W-4){1'b0}}, dig_val};
    end
  end

endmodule

// ----- rtl/core/numeric_literal_parser.sv -----
// ---------------------------------------------------------------------------
// numeric_literal_parser
// C-style integer literal parser: one character per transaction in, one
// signed 32-bit value out when the terminating NUL arrives.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one character per transaction (in_tdata[7:0]). A NUL (0) ends the
//           literal and produces exactly one out_* transaction; other
//           characters produce none.
//   out_* : parsed value, two's complement, wrapped to 32 bits; 0 when the
//           text is empty, a bare prefix or malformed.
//   Prefix 0b = binary, 0x = hex, leading 0 = octal, otherwise decimal;
//   one '-' is allowed right after the prefix.
// Output: a NUL accepted into the input register is evaluated there and its
//   result is written to the output register, which drives out_tvalid.
// Throughput: one character per cycle unless a NUL is held (see Stall); each
//   character is one shift-add from the input to the state/result registers.
// Reset: rst_n low clears the input and output stages and returns the
//   parser to the start of a literal.
// Stall: while out_tvalid waits on out_tready, ordinary characters keep
//   flowing; a NUL that finds the output register full holds in the input
//   register and in_tready drops until the result is taken.
// ---------------------------------------------------------------------------
`include "numeric_literal_parser_macros.svh"

module numeric_literal_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [nlp_pkg::CHAR_W-1:0]  in_tdata,   // [7:0] char_code
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [nlp_pkg::VALUE_W-1:0] out_tdata   // [31:0] value
);

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_ZERO   = 3'd1,
    PH_SIGN   = 3'd2,
    PH_DIGITS = 3'd3
  } phase_t;

  // Input stage
  logic                        in_vld_r;
  logic [nlp_pkg::CHAR_W-1:0]  in_char_r;

  // Parser state
  phase_t                      phase_r, phase_nxt;
  nlp_pkg::radix_t             radix_r, radix_nxt, eff_radix;
  logic [nlp_pkg::VALUE_W-1:0] accum_r, accum_nxt, step_accum;
  logic                        neg_r, neg_nxt;
  logic                        mal_r, mal_nxt, step_mal;

  // Output stage
  logic                        out_vld_r;
  logic [nlp_pkg::VALUE_W-1:0] out_data_r;

  logic                        is_nul;
  logic                        out_free;
  logic                        proc;
  logic                        sign_step;
  logic                        take_dig;
  logic [nlp_pkg::VALUE_W-1:0] result;

  assign is_nul    = (in_char_r == nlp_pkg::CHAR_NUL);
  assign out_free  = ~out_vld_r | out_tready;
  assign proc      = in_vld_r & (~is_nul | out_free);
  assign in_tready = ~in_vld_r | proc;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // Final value for a terminated literal
  assign result = mal_r ? '0 : (neg_r ? (~accum_r + 32'd1) : accum_r);

  nlp_digit_step u_digit_step (
    .char_i      (in_char_r),
    .radix_i     (eff_radix),
    .accum_i     (accum_r),
    .malformed_i (mal_r),
    .accum_o     (step_accum),
    .malformed_o (step_mal)
  );

  // Prefix / sign / digit sequencing
  always_comb begin
    phase_nxt = phase_r;
    radix_nxt = radix_r;
    accum_nxt = accum_r;
    neg_nxt   = neg_r;
    mal_nxt   = mal_r;
    eff_radix = radix_r;
    sign_step = 1'b0;
    take_dig  = 1'b0;

    case (phase_r)
      PH_START: begin
        if (in_char_r == nlp_pkg::CHAR_ZERO) begin
          phase_nxt = PH_ZERO;
        end else begin
          eff_radix = nlp_pkg::RADIX_DEC;
          sign_step = 1'b1;
        end
      end
      PH_ZERO: begin
        if (in_char_r == nlp_pkg::CHAR_B) begin
          radix_nxt = nlp_pkg::RADIX_BIN;
          phase_nxt = PH_SIGN;
        end else if (in_char_r == nlp_pkg::CHAR_X) begin
          radix_nxt = nlp_pkg::RADIX_HEX;
          phase_nxt = PH_SIGN;
        end else begin
          eff_radix = nlp_pkg::RADIX_OCT;
          sign_step = 1'b1;
        end
      end
      PH_SIGN: sign_step = 1'b1;
      default: take_dig = 1'b1;
    endcase

    // First character after the prefix may be the sign
    if (sign_step) begin
      radix_nxt = eff_radix;
      phase_nxt = PH_DIGITS;
      if (in_char_r == nlp_pkg::CHAR_MINUS) begin
        neg_nxt = 1'b1;
      end else begin
        take_dig = 1'b1;
      end
    end

    if (take_dig) begin
      accum_nxt = step_accum;
      mal_nxt   = step_mal;
    end

    // NUL returns to the start of a new literal
    if (is_nul) begin
      phase_nxt = PH_START;
      radix_nxt = nlp_pkg::RADIX_DEC;
      accum_nxt = '0;
      neg_nxt   = 1'b0;
      mal_nxt   = 1'b0;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_char_r <= in_tdata;
    end
  end

  // Parser state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_START;
      radix_r   <= nlp_pkg::RADIX_DEC;
      accum_r   <= '0;
      neg_r     <= 1'b0;
      mal_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (proc) begin
        phase_r <= phase_nxt;
        radix_r <= radix_nxt;
        accum_r <= accum_nxt;
        neg_r   <= neg_nxt;
        mal_r   <= mal_nxt;
      end
      if (proc && is_nul) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc && is_nul) begin
      out_data_r <= result;
    end
  end

  // Checks
  `NLP_ASSERT_NEXT(a_nul_restarts, proc && is_nul, phase_r == PH_START && !mal_r && !neg_r)
  `NLP_ASSERT_NOW(a_mal_in_digits, mal_r, phase_r == PH_DIGITS)
  `NLP_ASSERT_NOW(a_neg_in_digits, neg_r, phase_r == PH_DIGITS)
  `NLP_ASSERT_NEXT(a_nul_held, in_vld_r && is_nul && !out_free, in_vld_r && is_nul)

endmodule
